// File: hw/rtl/acia_register_model_top_assert.svh
// assertion macros shared by the serial adapter rtl
`ifndef ACIA_REGISTER_MODEL_TOP_ASSERT_SVH
`define ACIA_REGISTER_MODEL_TOP_ASSERT_SVH

// same-cycle implication
`define ACIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/acia_pkg.sv
// types and constants of the serial adapter register model
`timescale 1ns / 1ps
`default_nettype none

package acia_pkg;

   localparam int DELAY_BITS = 24;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 24'd33333;

   localparam logic [ADDR_BITS-3:0] REG_CHAR_DELAY = 1'b0;

   localparam logic [7:0] STATUS_RX_FULL  = 8'h01;
   localparam logic [7:0] STATUS_TX_EMPTY = 8'h02;
   localparam logic [7:0] STATUS_OVERRUN  = 8'h20;
   localparam logic [7:0] CTRL_MASTER_RESET = 8'h03;

   typedef enum logic [2:0] {
      KIND_CPU_READ  = 3'd0,
      KIND_CPU_WRITE = 3'd1,
      KIND_LINE_RX   = 3'd2,
      KIND_LINE_TAKE = 3'd3,
      KIND_TICK      = 3'd4
   } kind_type;

   typedef struct packed {
      logic       has_rsp;
      logic [7:0] data;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/acia_csr.sv
// apb-style configuration register holding the character delay
`timescale 1ns / 1ps
`default_nettype none

module acia_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [acia_pkg::ADDR_BITS-1:0]   paddr,
   input  wire logic [acia_pkg::DATA_BITS-1:0]   pwdata,
   output logic      [acia_pkg::DATA_BITS-1:0]   prdata,
   output logic                                  pready,
   output logic      [acia_pkg::DELAY_BITS-1:0]  char_delay
);

   logic [acia_pkg::DELAY_BITS-1:0] char_delay_ff;
   logic [acia_pkg::DELAY_BITS-1:0] char_delay_in;
   logic                            sel_delay;

   assign sel_delay = (paddr[acia_pkg::ADDR_BITS-1:2] == acia_pkg::REG_CHAR_DELAY);

   always_comb begin
      char_delay_in = char_delay_ff;
      if (psel && penable && pwrite && sel_delay) begin
         char_delay_in = pwdata[acia_pkg::DELAY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_delay_ff <= acia_pkg::DELAY_RESET;
      end else begin
         char_delay_ff <= char_delay_in;
      end
   end

   assign prdata = sel_delay
                 ? {{(acia_pkg::DATA_BITS-acia_pkg::DELAY_BITS){1'b0}}, char_delay_ff}
                 : '0;
   assign pready     = 1'b1;
   assign char_delay = char_delay_ff;

endmodule

`default_nettype wire

// File: hw/rtl/acia_core.sv
// adapter state: holding bytes, flags, elapsed-time counters and result select
`timescale 1ns / 1ps
`default_nettype none

module acia_core #(
   parameter int TIME_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             fire,
   input  wire logic [2:0]                       kind,
   input  wire logic                             reg_select,
   input  wire logic [7:0]                       data_in,
   input  wire logic [acia_pkg::DELAY_BITS-1:0]  char_delay,
   output acia_pkg::result_type                  result
);

`include "acia_register_model_top_assert.svh"

   localparam int CMP_BITS = (TIME_BITS > acia_pkg::DELAY_BITS)
                           ? TIME_BITS : acia_pkg::DELAY_BITS;

   logic [7:0]           rx_byte_ff, rx_byte_in;
   logic [7:0]           tx_byte_ff, tx_byte_in;
   logic                 rx_full_ff, rx_full_in;
   logic                 tx_empty_ff, tx_empty_in;
   logic                 overrun_ff, overrun_in;
   logic [TIME_BITS-1:0] rx_ticks_ff, rx_ticks_in;
   logic [TIME_BITS-1:0] tx_ticks_ff, tx_ticks_in;
   logic [7:0]           status;
   logic                 rx_due;
   logic                 tx_due;

   assign rx_due = CMP_BITS'(rx_ticks_ff) >= CMP_BITS'(char_delay);
   assign tx_due = CMP_BITS'(tx_ticks_ff) >= CMP_BITS'(char_delay);

   assign status = ((rx_full_ff && rx_due)  ? acia_pkg::STATUS_RX_FULL  : 8'h00)
                 | ((tx_empty_ff && tx_due) ? acia_pkg::STATUS_TX_EMPTY : 8'h00)
                 | (overrun_ff              ? acia_pkg::STATUS_OVERRUN  : 8'h00);

   always_comb begin
      rx_byte_in  = rx_byte_ff;
      tx_byte_in  = tx_byte_ff;
      rx_full_in  = rx_full_ff;
      tx_empty_in = tx_empty_ff;
      overrun_in  = overrun_ff;
      rx_ticks_in = rx_ticks_ff;
      tx_ticks_in = tx_ticks_ff;
      result.has_rsp = 1'b0;
      result.data    = 8'h00;
      unique case (kind)
         acia_pkg::KIND_CPU_READ: begin
            result.has_rsp = 1'b1;
            if (reg_select) begin
               result.data = rx_byte_ff;
               rx_full_in  = 1'b0;
               overrun_in  = 1'b0;
               rx_ticks_in = '0;
            end else begin
               result.data = status;
            end
         end
         acia_pkg::KIND_CPU_WRITE: begin
            if (reg_select) begin
               tx_byte_in  = data_in;
               tx_empty_in = 1'b0;
               tx_ticks_in = '0;
            end else if ((data_in & acia_pkg::CTRL_MASTER_RESET)
                         == acia_pkg::CTRL_MASTER_RESET) begin
               rx_full_in  = 1'b0;
               overrun_in  = 1'b0;
               tx_empty_in = 1'b1;
            end
         end
         acia_pkg::KIND_LINE_RX: begin
            overrun_in = overrun_ff | rx_full_ff;
            rx_full_in = 1'b1;
            rx_byte_in = data_in;
         end
         acia_pkg::KIND_LINE_TAKE: begin
            result.has_rsp = 1'b1;
            result.data    = tx_byte_ff;
            tx_empty_in    = 1'b1;
         end
         acia_pkg::KIND_TICK: begin
            rx_ticks_in = (&rx_ticks_ff) ? rx_ticks_ff : rx_ticks_ff + 1'b1;
            tx_ticks_in = (&tx_ticks_ff) ? tx_ticks_ff : tx_ticks_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_byte_ff  <= 8'h00;
         tx_byte_ff  <= 8'h00;
         rx_full_ff  <= 1'b0;
         tx_empty_ff <= 1'b1;
         overrun_ff  <= 1'b0;
         rx_ticks_ff <= '1;
         tx_ticks_ff <= '1;
      end else if (fire) begin
         rx_byte_ff  <= rx_byte_in;
         tx_byte_ff  <= tx_byte_in;
         rx_full_ff  <= rx_full_in;
         tx_empty_ff <= tx_empty_in;
         overrun_ff  <= overrun_in;
         rx_ticks_ff <= rx_ticks_in;
         tx_ticks_ff <= tx_ticks_in;
      end
   end

   `ACIA_ASSERT_NEXT(a_data_read_clears, clock, reset,
      fire && kind == acia_pkg::KIND_CPU_READ && reg_select,
      !rx_full_ff && !overrun_ff && rx_ticks_ff == '0,
      "data read did not clear receive state")

   `ACIA_ASSERT_NEXT(a_tick_counts, clock, reset,
      fire && kind == acia_pkg::KIND_TICK && !(&rx_ticks_ff),
      rx_ticks_ff == TIME_BITS'($past(rx_ticks_ff) + 1'b1),
      "receive tick counter did not advance")

   `ACIA_ASSERT_NEXT(a_overrun_source, clock, reset,
      fire && kind == acia_pkg::KIND_LINE_RX && rx_full_ff,
      overrun_ff && rx_full_ff,
      "receive into full holding byte did not flag overrun")

endmodule

`default_nettype wire

// File: hw/rtl/acia_register_model_top.sv
// serial adapter register model: input stage, state core, result register
// a taken beat is held in the input stage, then its result in the result register
// throughput: one unstalled beat per cycle, set by the single-pass update of the core state
// a held result stalls the input only while the staged beat also returns a result
// reset: synchronous, active high; flags, bytes, counters and delay reset at once
`timescale 1ns / 1ps
`default_nettype none

module acia_register_model_top #(
   parameter int TIME_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [2:0]                       req_kind,
   input  wire logic                             req_reg_select,
   input  wire logic [7:0]                       req_data_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [7:0]                       rsp_read_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [acia_pkg::ADDR_BITS-1:0]   paddr,
   input  wire logic [acia_pkg::DATA_BITS-1:0]   pwdata,
   output logic      [acia_pkg::DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

`include "acia_register_model_top_assert.svh"

   logic                            s1_valid_ff, s1_valid_in;
   logic [2:0]                      s1_kind_ff;
   logic                            s1_sel_ff;
   logic [7:0]                      s1_data_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_data_ff;
   logic                            out_free;
   logic                            s1_advance;
   logic                            req_take;
   logic [acia_pkg::DELAY_BITS-1:0] char_delay;
   acia_pkg::result_type            result;

   acia_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .char_delay (char_delay)
   );

   acia_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_advance),
      .kind       (s1_kind_ff),
      .reg_select (s1_sel_ff),
      .data_in    (s1_data_ff),
      .char_delay (char_delay),
      .result     (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!result.has_rsp || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_advance && result.has_rsp) ? 1'b1
                   : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= req_kind;
         s1_sel_ff  <= req_reg_select;
         s1_data_ff <= req_data_in;
      end
      if (s1_advance && result.has_rsp) begin
         rsp_data_ff <= result.data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   `ACIA_ASSERT_NOW(a_result_slot_guard, clock, reset,
      rsp_valid_ff && !rsp_ready && s1_valid_ff && result.has_rsp,
      !s1_advance,
      "result beat would overwrite a held result")

   `ACIA_ASSERT_NOW(a_stall_means_busy, clock, reset,
      !req_ready,
      s1_valid_ff && result.has_rsp && rsp_valid_ff,
      "request stalled without a held result")

   `ACIA_ASSERT_NEXT(a_result_follows, clock, reset,
      s1_advance && result.has_rsp,
      rsp_valid_ff,
      "result beat lost after core update")

endmodule

`default_nettype wire
